### design/crc_fur_pkg.sv
// crc_fur_pkg: types, constants and the crc-16 byte update for the framed receiver
// no dependencies; imported by the interfaces, the parser and the top level
`default_nettype none

package crc_fur_pkg;

   // frame delimiters
   localparam logic [7:0]  SOF_BYTE  = 8'h7E;
   localparam logic [7:0]  STOP_BYTE = 8'h7F;

   // crc-16/ccitt-false
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // parser phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SEQ,
      PH_LEN,
      PH_DATA,
      PH_CRC_HI,
      PH_CRC_LO,
      PH_END
   } phase_type;

   // frame status codes
   typedef enum logic [1:0] {
      ST_NEW     = 2'd0,
      ST_DUP     = 2'd1,
      ST_CRC_ERR = 2'd2,
      ST_BAD_EOF = 2'd3
   } status_type;

   // one result item
   typedef struct packed {
      status_type  frame_status;
      logic [7:0]  frame_seq;
      logic [6:0]  frame_length;
      logic        ack_request;
      logic        ack_suppressed;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
   } result_type;

   // msb-first crc update over one byte
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### design/crc_fur_ifs.sv
// crc_fur_ifs: valid/ready channel interfaces for byte requests, results and csr writes
// depends on crc_fur_pkg for the result status type
`default_nettype none

// received byte channel
interface crc_fur_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// frame result channel
interface crc_fur_rsp_if
   import crc_fur_pkg::*;
;
   logic        valid;
   logic        ready;
   status_type  frame_status;
   logic [7:0]  frame_seq;
   logic [6:0]  frame_length;
   logic        ack_request;
   logic        ack_suppressed;
   logic [15:0] received_crc;
   logic [15:0] computed_crc;

   modport source (output valid, output frame_status, output frame_seq, output frame_length,
                   output ack_request, output ack_suppressed, output received_crc,
                   output computed_crc, input ready);
   modport sink   (input valid, input frame_status, input frame_seq, input frame_length,
                   input ack_request, input ack_suppressed, input received_crc,
                   input computed_crc, output ready);
endinterface

// ack drop interval write channel
interface crc_fur_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] ack_drop_interval;

   modport source (output valid, output ack_drop_interval, input ready);
   modport sink   (input valid, input ack_drop_interval, output ready);
endinterface

`default_nettype wire

### design/crc_framed_uart_receiver.sv
// crc_framed_uart_receiver: one received byte per cycle, one status result at each frame end.
// A result is queued as its end byte is accepted and goes out on rsp after any older one.
// Throughput: one byte per cycle; a two-entry result queue keeps bytes flowing while
// rsp stalls, and req backs off only when both entries are full.
// Reset (synchronous, active high): parser idle waiting for start, crc 0xFFFF, queue empty,
// ack drop interval 0.
`default_nettype none

module crc_framed_uart_receiver
   import crc_fur_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input wire logic   clock,
   input wire logic   reset,
   crc_fur_req_if.sink   req_if,
   crc_fur_rsp_if.source rsp_if,
   crc_fur_csr_if.sink   csr_if
);

   logic [15:0] drop_interval_ff;
   logic        req_accept;
   logic        push;
   logic        pop;
   result_type  parser_result;

   result_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;

   // csr register
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_interval_ff <= 16'd0;
      end else if (csr_if.valid) begin
         drop_interval_ff <= csr_if.ack_drop_interval;
      end
   end

   // request side
   assign req_if.ready = (count_ff != 2'd2);
   assign req_accept   = req_if.valid && req_if.ready;

   crc_fur_parser #(
      .MAX_LEN (MAX_LEN)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .byte_valid        (req_accept),
      .rx_byte           (req_if.rx_byte),
      .ack_drop_interval (drop_interval_ff),
      .result_valid      (push),
      .result            (parser_result)
   );

   // result queue control
   assign pop = rsp_if.valid && rsp_if.ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= parser_result;
      end
   end

   // response side
   assign rsp_if.valid          = (count_ff != 2'd0);
   assign rsp_if.frame_status   = entry_ff[rd_ptr_ff].frame_status;
   assign rsp_if.frame_seq      = entry_ff[rd_ptr_ff].frame_seq;
   assign rsp_if.frame_length   = entry_ff[rd_ptr_ff].frame_length;
   assign rsp_if.ack_request    = entry_ff[rd_ptr_ff].ack_request;
   assign rsp_if.ack_suppressed = entry_ff[rd_ptr_ff].ack_suppressed;
   assign rsp_if.received_crc   = entry_ff[rd_ptr_ff].received_crc;
   assign rsp_if.computed_crc   = entry_ff[rd_ptr_ff].computed_crc;

endmodule

`default_nettype wire

### design/crc_fur_parser.sv
// crc_fur_parser: frame state machine with on-the-fly crc and ack fault injection
// depends on crc_fur_pkg; produces at most one result per accepted byte
`default_nettype none

module crc_fur_parser
   import crc_fur_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        byte_valid,
   input  wire logic [7:0]  rx_byte,
   input  wire logic [15:0] ack_drop_interval,
   output      logic        result_valid,
   output      result_type  result
);

   phase_type   phase_ff,      phase_in;
   logic [7:0]  seq_ff,        seq_in;
   logic [7:0]  length_ff,     length_in;
   logic [7:0]  seen_ff,       seen_in;
   logic [15:0] crc_ff,        crc_in;
   logic [15:0] rx_crc_ff,     rx_crc_in;
   logic [7:0]  prior_seq_ff,  prior_seq_in;
   logic        seq_known_ff,  seq_known_in;
   logic [15:0] drop_phase_ff, drop_phase_in;

   logic [15:0] crc_next;
   logic [7:0]  seen_next;
   logic [15:0] drop_next;
   logic        drop;

   assign crc_next  = crc_feed(crc_ff, rx_byte);
   assign seen_next = seen_ff + 8'd1;
   assign drop_next = drop_phase_ff + 16'd1;
   assign drop      = (ack_drop_interval != 16'd0) && (drop_next >= ack_drop_interval);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         seq_ff        <= 8'd0;
         length_ff     <= 8'd0;
         seen_ff       <= 8'd0;
         crc_ff        <= CRC_INIT;
         rx_crc_ff     <= 16'd0;
         prior_seq_ff  <= 8'd0;
         seq_known_ff  <= 1'b0;
         drop_phase_ff <= 16'd0;
      end else begin
         phase_ff      <= phase_in;
         seq_ff        <= seq_in;
         length_ff     <= length_in;
         seen_ff       <= seen_in;
         crc_ff        <= crc_in;
         rx_crc_ff     <= rx_crc_in;
         prior_seq_ff  <= prior_seq_in;
         seq_known_ff  <= seq_known_in;
         drop_phase_ff <= drop_phase_in;
      end
   end

   // next state and result
   always_comb begin
      phase_in      = phase_ff;
      seq_in        = seq_ff;
      length_in     = length_ff;
      seen_in       = seen_ff;
      crc_in        = crc_ff;
      rx_crc_in     = rx_crc_ff;
      prior_seq_in  = prior_seq_ff;
      seq_known_in  = seq_known_ff;
      drop_phase_in = drop_phase_ff;

      result_valid          = 1'b0;
      result.frame_status   = ST_BAD_EOF;
      result.frame_seq      = seq_ff;
      result.frame_length   = length_ff[6:0];
      result.ack_request    = 1'b0;
      result.ack_suppressed = 1'b0;
      result.received_crc   = rx_crc_ff;
      result.computed_crc   = 16'd0;

      if (byte_valid) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (rx_byte == SOF_BYTE) begin
                  crc_in   = CRC_INIT;
                  phase_in = PH_SEQ;
               end
            end
            PH_SEQ: begin
               seq_in   = rx_byte;
               crc_in   = crc_next;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               length_in = rx_byte;
               crc_in    = crc_next;
               seen_in   = 8'd0;
               if ({1'b0, rx_byte} > 9'(MAX_LEN)) begin
                  phase_in = PH_IDLE;
               end else if (rx_byte == 8'd0) begin
                  phase_in = PH_CRC_HI;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               crc_in  = crc_next;
               seen_in = seen_next;
               if (seen_next >= length_ff) begin
                  phase_in = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               rx_crc_in = {rx_byte, 8'h00};
               phase_in  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               rx_crc_in = {rx_crc_ff[15:8], rx_byte};
               phase_in  = PH_END;
            end
            PH_END: begin
               result_valid = 1'b1;
               phase_in     = PH_IDLE;
               if (rx_byte == STOP_BYTE) begin
                  result.computed_crc = crc_ff;
                  if (crc_ff != rx_crc_ff) begin
                     result.frame_status = ST_CRC_ERR;
                  end else begin
                     // fault injection counter
                     if (ack_drop_interval == 16'd0 || drop) begin
                        drop_phase_in = 16'd0;
                     end else begin
                        drop_phase_in = drop_next;
                     end
                     // duplicate detection
                     if (seq_known_ff && seq_ff == prior_seq_ff) begin
                        result.frame_status = ST_DUP;
                     end else begin
                        result.frame_status = ST_NEW;
                        prior_seq_in        = seq_ff;
                        seq_known_in        = 1'b1;
                     end
                     result.ack_request    = !drop;
                     result.ack_suppressed = drop;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
